>>> src/xlsu_pkg.sv
// Shared types and codes for the x86 logic and shift unit.
// Used by xlsu_exec and x86_logic_shift_unit; depends on nothing.
`default_nettype none

package xlsu_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [3:0] {
        ACT_TEST  = 4'd0,
        ACT_AND   = 4'd1,
        ACT_XOR   = 4'd2,
        ACT_OR    = 4'd3,
        ACT_SAR   = 4'd4,
        ACT_SHL   = 4'd5,
        ACT_SHR   = 4'd6,
        ACT_SETCC = 4'd7,
        ACT_NOT   = 4'd8,
        ACT_ROL   = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        W_BYTE  = 2'd0,
        W_WORD  = 2'd1,
        W_DWORD = 2'd2,
        W_NONE  = 2'd3
    } width_t;

    // Condition pairs selected by cond_code[3:1]; cond_code[0] inverts.
    typedef enum logic [2:0] {
        CG_O  = 3'd0,
        CG_B  = 3'd1,
        CG_E  = 3'd2,
        CG_BE = 3'd3,
        CG_S  = 3'd4,
        CG_P  = 3'd5,
        CG_L  = 3'd6,
        CG_LE = 3'd7
    } cond_grp_t;

    typedef struct packed {
        logic [3:0]       action;
        logic [DataW-1:0] dest_value;
        logic [DataW-1:0] src_value;
        logic [1:0]       width_code;
        logic [3:0]       cond_code;
        logic             zf;
        logic             sf;
        logic             cf;
        logic             of;
    } exec_in_t;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             write_dest;
        logic             zf;
        logic             sf;
        logic             cf;
        logic             of;
        logic             error;
    } exec_out_t;

endpackage

`default_nettype wire

>>> src/xlsu_exec.sv
// Combinational datapath of the x86 logic and shift unit: logic ops,
// barrel shifts, rotate, SETcc and flag update. Depends on xlsu_pkg.
`default_nettype none

module xlsu_exec (
    input  xlsu_pkg::exec_in_t  op,
    output xlsu_pkg::exec_out_t res
);
    import xlsu_pkg::*;

    logic [DataW-1:0] mask;
    logic [DataW-1:0] msb;
    logic [DataW-1:0] d;
    logic [DataW-1:0] s;
    logic [DataW-1:0] ext;
    logic [DataW-1:0] sar_val;
    logic [DataW-1:0] rot_val;
    logic [4:0]       cnt;
    logic [15:0]      rot8_w;
    logic [31:0]      rot16_w;
    logic [63:0]      rot32_w;
    logic             width_bad;
    logic             cond_base;
    logic             cond_err;
    logic             cond_val;
    logic             upd_zs;
    logic [DataW-1:0] value;

    always_comb
    begin
        unique case (width_t'(op.width_code))
            W_BYTE:
            begin
                mask      = 32'h0000_00FF;
                msb       = 32'h0000_0080;
                width_bad = 1'b0;
            end
            W_WORD:
            begin
                mask      = 32'h0000_FFFF;
                msb       = 32'h0000_8000;
                width_bad = 1'b0;
            end
            W_DWORD:
            begin
                mask      = 32'hFFFF_FFFF;
                msb       = 32'h8000_0000;
                width_bad = 1'b0;
            end
            W_NONE:
            begin
                mask      = '0;
                msb       = '0;
                width_bad = 1'b1;
            end
        endcase
    end

    assign d   = op.dest_value & mask;
    assign s   = op.src_value & mask;
    assign cnt = op.src_value[4:0];

    // Sign-extend to 32 bits so the arithmetic shift fills from the operand's top bit.
    assign ext     = ((d & msb) != '0) ? (d | ~mask) : d;
    assign sar_val = DataW'($signed(ext) >>> cnt) & mask;

    // The upper half of a doubled operand shifted left is the left rotate.
    assign rot8_w  = {d[7:0], d[7:0]} << cnt[2:0];
    assign rot16_w = {d[15:0], d[15:0]} << cnt[3:0];
    assign rot32_w = {d, d} << cnt;

    always_comb
    begin
        unique case (width_t'(op.width_code))
            W_BYTE:  rot_val = {24'd0, rot8_w[15:8]};
            W_WORD:  rot_val = {16'd0, rot16_w[31:16]};
            W_DWORD: rot_val = rot32_w[63:32];
            W_NONE:  rot_val = '0;
        endcase
    end

    always_comb
    begin
        cond_err = 1'b0;
        unique case (cond_grp_t'(op.cond_code[3:1]))
            CG_O:  cond_base = op.of;
            CG_B:  cond_base = op.cf;
            CG_E:  cond_base = op.zf;
            CG_BE: cond_base = op.cf | op.zf;
            CG_S:  cond_base = op.sf;
            CG_P:
            begin
                cond_base = 1'b0;
                cond_err  = 1'b1;
            end
            CG_L:  cond_base = op.sf ^ op.of;
            CG_LE: cond_base = op.zf | (op.sf ^ op.of);
        endcase
    end

    assign cond_val = cond_base ^ op.cond_code[0];

    always_comb
    begin
        value          = '0;
        upd_zs         = 1'b0;
        res.write_dest = 1'b0;
        res.cf         = op.cf;
        res.of         = op.of;
        res.error      = 1'b0;
        if (width_bad)
        begin
            res.error = 1'b1;
        end
        else
        begin
            unique case (action_t'(op.action))
                ACT_TEST:
                begin
                    value  = d & s;
                    upd_zs = 1'b1;
                    res.cf = 1'b0;
                    res.of = 1'b0;
                end
                ACT_AND:
                begin
                    value          = d & s;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                    res.cf         = 1'b0;
                    res.of         = 1'b0;
                end
                ACT_XOR:
                begin
                    value          = d ^ s;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                    res.cf         = 1'b0;
                    res.of         = 1'b0;
                end
                ACT_OR:
                begin
                    value          = d | s;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                    res.cf         = 1'b0;
                    res.of         = 1'b0;
                end
                ACT_SAR:
                begin
                    value          = sar_val;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                end
                ACT_SHL:
                begin
                    value          = (d << cnt) & mask;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                end
                ACT_SHR:
                begin
                    value          = d >> cnt;
                    upd_zs         = 1'b1;
                    res.write_dest = 1'b1;
                end
                ACT_SETCC:
                begin
                    if (cond_err)
                    begin
                        res.error = 1'b1;
                    end
                    else
                    begin
                        value          = {{(DataW-1){1'b0}}, cond_val};
                        res.write_dest = 1'b1;
                    end
                end
                ACT_NOT:
                begin
                    value          = ~d & mask;
                    res.write_dest = 1'b1;
                end
                ACT_ROL:
                begin
                    value          = rot_val;
                    res.write_dest = 1'b1;
                end
                default:
                begin
                    res.error = 1'b1;
                end
            endcase
        end
        res.value = value;
        res.zf    = upd_zs ? (value == '0) : op.zf;
        res.sf    = upd_zs ? ((value & msb) != '0) : op.sf;
    end

endmodule

`default_nettype wire

>>> src/x86_logic_shift_unit.sv
// Top level of the x86 logic and shift unit: input register, execute
// datapath (xlsu_exec) and output register. Depends on xlsu_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one instruction item:
//   action, operands, operand width, SETcc condition and the current flags.
//   The output channel (out_valid/out_ready) returns one result item per
//   input item: the destination value, its write enable, the four updated
//   flags and an error bit.
//   An item taken from the input is held in the input register, run through
//   the combinational execute logic, and loaded into the output register.
//   Throughput is one item per cycle while out_ready stays high, set by the
//   one-pass execute stage between the two registers.
//   When the receiver stalls, the output register holds its item and the
//   input register keeps one more; in_ready drops only when both are full.
//   Reset empties both registers; no result is shown until an item arrives.
`default_nettype none

module x86_logic_shift_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] dest_value,
    input  wire logic [31:0] src_value,
    input  wire logic [1:0]  width_code,
    input  wire logic [3:0]  cond_code,
    input  wire logic        zf_in,
    input  wire logic        sf_in,
    input  wire logic        cf_in,
    input  wire logic        of_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_value,
    output logic             write_dest,
    output logic             zf_out,
    output logic             sf_out,
    output logic             cf_out,
    output logic             of_out,
    output logic             error
);
    import xlsu_pkg::*;

    exec_in_t  op_reg;
    exec_in_t  op_next;
    logic      op_valid_reg;
    logic      op_valid_next;
    exec_out_t res_reg;
    exec_out_t exec_res;
    logic      res_valid_reg;
    logic      res_valid_next;
    logic      res_load;
    logic      in_take;

    // The output register can load when empty or being drained this cycle.
    assign res_load = !res_valid_reg || out_ready;
    assign in_ready = !op_valid_reg || res_load;
    assign in_take  = in_valid && in_ready;

    assign op_next = '{
        action:     action,
        dest_value: dest_value,
        src_value:  src_value,
        width_code: width_code,
        cond_code:  cond_code,
        zf:         zf_in,
        sf:         sf_in,
        cf:         cf_in,
        of:         of_in
    };

    assign op_valid_next  = in_take ? 1'b1 : (op_valid_reg && !res_load);
    assign res_valid_next = res_load ? op_valid_reg : res_valid_reg;

    xlsu_exec u_exec (
        .op  (op_reg),
        .res (exec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= op_next;
        end
        if (res_load && op_valid_reg)
        begin
            res_reg <= exec_res;
        end
    end

    assign out_valid    = res_valid_reg;
    assign result_value = res_reg.value;
    assign write_dest   = res_reg.write_dest;
    assign zf_out       = res_reg.zf;
    assign sf_out       = res_reg.sf;
    assign cf_out       = res_reg.cf;
    assign of_out       = res_reg.of;
    assign error        = res_reg.error;

    // An errored item never writes and carries a zero value.
    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> !write_dest && (result_value == '0))
        else $error("error result with write or nonzero value");

    // A held input item stays put until the output side can take it.
    a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && !res_load |=> op_valid_reg && $stable(op_reg))
        else $error("input register lost or changed a stalled item");

    // A registered item moves into the output register when it can load.
    a_op_advance: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid_reg && res_load |=> res_valid_reg)
        else $error("registered item did not reach the output");

    // Backpressure reaches the input only when both registers are full.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> op_valid_reg && res_valid_reg && !out_ready)
        else $error("in_ready low without a full pipeline");

endmodule

`default_nettype wire

>>> bench/xlsu_checker.sv
// Result checker for the x86 logic and shift unit: watches both channels,
// predicts each result from the accepted instruction item and compares.
// Depends on xlsu_pkg for the action, width and condition codes.

module xlsu_checker
    import xlsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  action,
    input  logic [31:0] dest_value,
    input  logic [31:0] src_value,
    input  logic [1:0]  width_code,
    input  logic [3:0]  cond_code,
    input  logic        zf_in,
    input  logic        sf_in,
    input  logic        cf_in,
    input  logic        of_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] result_value,
    input  logic        write_dest,
    input  logic        zf_out,
    input  logic        sf_out,
    input  logic        cf_out,
    input  logic        of_out,
    input  logic        error,
    output int          fail_count,
    output int          outstanding
);

    exec_out_t awaited_results[$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic exec_out_t execute_instr(
        input logic [3:0]  act,
        input logic [31:0] d_raw,
        input logic [31:0] s_raw,
        input logic [1:0]  wc,
        input logic [3:0]  cc,
        input logic        zf,
        input logic        sf,
        input logic        cf,
        input logic        of
    );
        exec_out_t   r;
        int unsigned bits;
        int unsigned rot;
        logic [31:0] mask;
        logic [31:0] msb;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] ext;
        logic [4:0]  cnt;
        logic        cond_base;
        logic        set_zs;

        r = '0;
        r.zf = zf;
        r.sf = sf;
        r.cf = cf;
        r.of = of;
        set_zs = 1'b0;
        if (width_t'(wc) == W_NONE || act > ACT_ROL)
        begin
            r.error = 1'b1;
            return r;
        end
        bits = 8 << wc;
        mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        msb  = 32'd1 << (bits - 1);
        d    = d_raw & mask;
        s    = s_raw & mask;
        cnt  = s_raw[4:0];
        case (action_t'(act))
            ACT_TEST, ACT_AND, ACT_XOR, ACT_OR:
            begin
                if (action_t'(act) == ACT_XOR)
                    r.value = d ^ s;
                else if (action_t'(act) == ACT_OR)
                    r.value = d | s;
                else
                    r.value = d & s;
                r.write_dest = (action_t'(act) != ACT_TEST);
                r.cf = 1'b0;
                r.of = 1'b0;
                set_zs = 1'b1;
            end
            ACT_SAR:
            begin
                // Sign-extend to 32 bits so the arithmetic shift fills with the operand's sign.
                ext = ((d & msb) != 0) ? (d | ~mask) : d;
                r.value = 32'($signed(ext) >>> cnt) & mask;
                r.write_dest = 1'b1;
                set_zs = 1'b1;
            end
            ACT_SHL:
            begin
                r.value = (d << cnt) & mask;
                r.write_dest = 1'b1;
                set_zs = 1'b1;
            end
            ACT_SHR:
            begin
                r.value = d >> cnt;
                r.write_dest = 1'b1;
                set_zs = 1'b1;
            end
            ACT_SETCC:
            begin
                case (cond_grp_t'(cc[3:1]))
                    CG_O:    cond_base = of;
                    CG_B:    cond_base = cf;
                    CG_E:    cond_base = zf;
                    CG_BE:   cond_base = cf | zf;
                    CG_S:    cond_base = sf;
                    CG_L:    cond_base = sf ^ of;
                    default: cond_base = zf | (sf ^ of);
                endcase
                if (cond_grp_t'(cc[3:1]) == CG_P)
                begin
                    r.error = 1'b1;
                end
                else
                begin
                    r.value = {31'd0, cond_base ^ cc[0]};
                    r.write_dest = 1'b1;
                end
            end
            ACT_NOT:
            begin
                r.value = ~d & mask;
                r.write_dest = 1'b1;
            end
            default:
            begin
                rot = cnt % bits;
                if (rot == 0)
                    r.value = d;
                else
                    r.value = ((d << rot) | (d >> (bits - rot))) & mask;
                r.write_dest = 1'b1;
            end
        endcase
        if (set_zs)
        begin
            r.zf = (r.value == 0);
            r.sf = ((r.value & msb) != 0);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (act !== exp)
        begin
            $error("%s mismatch: expected %h, actual %h", name, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        exec_out_t exp;
        if (rst_n)
        begin
            // Retire before queuing so a result never meets an item taken at the same edge.
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result item with no instruction item pending");
                    fail_count++;
                end
                else
                begin
                    exp = awaited_results.pop_front();
                    check_field("result_value", exp.value, result_value);
                    check_field("write_dest", 32'(exp.write_dest), 32'(write_dest));
                    check_field("zf_out", 32'(exp.zf), 32'(zf_out));
                    check_field("sf_out", 32'(exp.sf), 32'(sf_out));
                    check_field("cf_out", 32'(exp.cf), 32'(cf_out));
                    check_field("of_out", 32'(exp.of), 32'(of_out));
                    check_field("error", 32'(exp.error), 32'(error));
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(execute_instr(action, dest_value, src_value,
                    width_code, cond_code, zf_in, sf_in, cf_in, of_in));
            outstanding <= awaited_results.size();
        end
    end

endmodule

>>> bench/x86_logic_shift_unit_tb.sv
// Top of the x86 logic and shift unit bench: clock, reset, instruction
// stimulus, receiver stalls and the verdict. Depends on xlsu_pkg,
// xlsu_checker and x86_logic_shift_unit.

module x86_logic_shift_unit_tb;
    import xlsu_pkg::*;

    localparam int RandomItems = 950;
    localparam int IdleLimit   = 1000;
    localparam int HoldCycles  = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  action = ACT_TEST;
    logic [31:0] dest_value = '0;
    logic [31:0] src_value = '0;
    logic [1:0]  width_code = W_BYTE;
    logic [3:0]  cond_code = '0;
    logic        zf_in = 1'b0;
    logic        sf_in = 1'b0;
    logic        cf_in = 1'b0;
    logic        of_in = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] result_value;
    logic        write_dest;
    logic        zf_out;
    logic        sf_out;
    logic        cf_out;
    logic        of_out;
    logic        error;
    int          fail_count;
    int          outstanding;

    int burst_left = 0;

    x86_logic_shift_unit DUT (.*);

    xlsu_checker u_checker (.*);

    always #2 clk = ~clk;

    // Flags are packed as {zf, sf, cf, of}.
    task automatic send_item(input logic [3:0] act, input logic [31:0] d, input logic [31:0] s,
                             input logic [1:0] w, input logic [3:0] cc, input logic [3:0] flags);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        action     <= act;
        dest_value <= d;
        src_value  <= s;
        width_code <= w;
        cond_code  <= cc;
        {zf_in, sf_in, cf_in, of_in} <= flags;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0080;
            3:       return 32'h0000_8000;
            4:       return 32'h8000_0000;
            5:       return 32'h7FFF_FF7F;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_item();
        logic [3:0]  act;
        logic [1:0]  w;
        logic [31:0] s;
        if ($urandom_range(0, 19) == 0)
            act = ACT_ROL + 4'($urandom_range(1, 6));
        else
            act = 4'($urandom_range(ACT_TEST, ACT_ROL));
        w = ($urandom_range(0, 9) == 0) ? W_NONE : 2'($urandom_range(W_BYTE, W_DWORD));
        if ((act == ACT_SAR || act == ACT_SHL || act == ACT_SHR || act == ACT_ROL)
            && $urandom_range(0, 1) == 0)
            s = (32'($urandom()) & 32'hFFFF_FFC0) | 32'($urandom_range(0, 40));
        else
            s = pick_operand();
        send_item(act, pick_operand(), s, w, 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
    endtask

    // Receiver: switches between stall patterns, with long hold-offs now and then.
    initial
    begin
        int cycle_count;
        int mode;
        int mode_left;
        int hold_left;
        logic ready_next;
        cycle_count = 0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count == 400 || cycle_count % 2500 == 0)
                hold_left = HoldCycles;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
                0:       ready_next = 1'b1;
                1:       ready_next = $urandom_range(0, 1);
                2:       ready_next = (cycle_count % 4 == 0);
                default: ready_next = ($urandom_range(0, 9) != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            out_ready <= ready_next;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Logic group: zero and sign results, flags cleared, upper bits ignored.
        send_item(ACT_TEST, 32'hFFFF_FFFF, 32'h0000_0000, W_BYTE, '0, 4'b0011);
        send_item(ACT_AND, 32'hFFFF_FFFF, 32'h8000_0000, W_DWORD, '0, 4'b1011);
        send_item(ACT_AND, 32'hFFFF_FF00, 32'hFFFF_FFFF, W_BYTE, '0, 4'b0111);
        send_item(ACT_XOR, 32'h0000_1234, 32'hFFFF_1234, W_WORD, '0, 4'b0000);
        send_item(ACT_OR, 32'h0000_0080, 32'h0000_0001, W_BYTE, '0, 4'b1111);
        // Shifts and NOT: counts past the width, a zero count, and counts above five bits.
        send_item(ACT_SAR, 32'h0000_0080, 32'd3, W_BYTE, '0, 4'b0011);
        send_item(ACT_SAR, 32'h0000_0080, 32'd9, W_BYTE, '0, 4'b0000);
        send_item(ACT_SAR, 32'h8000_0000, 32'd31, W_DWORD, '0, 4'b0101);
        send_item(ACT_SAR, 32'hFFFF_0000, 32'd0, W_WORD, '0, 4'b0110);
        send_item(ACT_SHL, 32'h0000_0081, 32'd8, W_BYTE, '0, 4'b0010);
        send_item(ACT_SHL, 32'h0000_0001, 32'h0000_003F, W_DWORD, '0, 4'b1001);
        send_item(ACT_SHR, 32'h0000_FFFF, 32'd16, W_WORD, '0, 4'b0100);
        send_item(ACT_SHR, 32'hFFFF_FFFF, 32'h0000_0020, W_DWORD, '0, 4'b1111);
        send_item(ACT_NOT, 32'h0000_000F, 32'hFFFF_FFFF, W_BYTE, '0, 4'b1111);
        send_item(ACT_NOT, 32'h0000_0000, 32'h0000_0000, W_DWORD, '0, 4'b0000);
        // Rotates: the count wraps modulo the width.
        send_item(ACT_ROL, 32'h0000_0081, 32'd9, W_BYTE, '0, 4'b1010);
        send_item(ACT_ROL, 32'h0000_8001, 32'd16, W_WORD, '0, 4'b0101);
        send_item(ACT_ROL, 32'h8000_0001, 32'h0000_0021, W_DWORD, '0, 4'b0000);
        // Conditions, the parity pair among them.
        send_item(ACT_SETCC, 32'hFFFF_FFFF, '0, W_DWORD, {CG_O, 1'b0}, 4'b0001);
        send_item(ACT_SETCC, '0, '0, W_BYTE, {CG_E, 1'b1}, 4'b0000);
        send_item(ACT_SETCC, '0, '0, W_WORD, {CG_P, 1'b0}, 4'b1111);
        send_item(ACT_SETCC, '0, '0, W_WORD, {CG_P, 1'b1}, 4'b0000);
        send_item(ACT_SETCC, '0, '0, W_BYTE, {CG_LE, 1'b1}, 4'b0101);
        // Unsupported width and unknown actions.
        send_item(ACT_AND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, W_NONE, '0, 4'b1010);
        send_item(ACT_ROL + 4'd1, 32'hFFFF_FFFF, 32'd1, W_BYTE, '0, 4'b0101);
        send_item(ACT_ROL + 4'd6, 32'h1234_5678, 32'd5, W_DWORD, '0, 4'b1111);

        for (int i = 0; i < RandomItems; i++)
            send_random_item();
        in_valid <= 1'b0;

        // The checker's count of pending items is a registered copy of its queue size.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
